### rtl/pcxd_pkg.sv
// ----------------------------------------------------------------------------
// pcxd_pkg
// Shared constants and types of the planar PCX RLE to RGB565 decoder.
// ----------------------------------------------------------------------------
package pcxd_pkg;

   localparam int MAX_PITCH = 1024;
   localparam int COL_W     = $clog2(MAX_PITCH);
   // wide enough for a pitch, a width or a column plus one
   localparam int CNT_W     = (COL_W + 1 > 11) ? COL_W + 1 : 11;
   localparam int RG_W      = 11;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_PITCH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam logic [7:0] RUN_MARK = 8'hC0;

   typedef logic [1:0] plane_type;

   localparam plane_type PLANE_RED   = 2'd0;
   localparam plane_type PLANE_GREEN = 2'd1;
   localparam plane_type PLANE_BLUE  = 2'd2;

   // one column step in flight between line-store read and write-back
   typedef struct packed {
      logic             valid;
      plane_type        plane;
      logic [COL_W-1:0] col;
      logic [7:0]       value;
      logic             emit;
      logic             eol;
      logic             eoi;
      logic             last;
      logic             fwd;
      logic [RG_W-1:0]  fwd_data;
   } step_type;

endpackage

### rtl/pcxd_req_if.sv
// ----------------------------------------------------------------------------
// pcxd_req_if
// Encoded byte channel of the decoder.
// ----------------------------------------------------------------------------
interface pcxd_req_if;

   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);

endinterface

### rtl/pcxd_rsp_if.sv
// ----------------------------------------------------------------------------
// pcxd_rsp_if
// Decoded pixel channel of the decoder.
// ----------------------------------------------------------------------------
interface pcxd_rsp_if;

   logic        valid;
   logic        ready;
   logic [15:0] pixel_rgb565;
   logic [9:0]  column;
   logic        end_of_line;
   logic        end_of_image;
   logic        last;

   modport source (output valid, output pixel_rgb565, output column,
                   output end_of_line, output end_of_image, output last,
                   input ready);
   modport sink   (input valid, input pixel_rgb565, input column,
                   input end_of_line, input end_of_image, input last,
                   output ready);

endinterface

### rtl/pcxd_line_ram.sv
// ----------------------------------------------------------------------------
// pcxd_line_ram
// Single-port-write, single-port-read line store with registered read data.
// ----------------------------------------------------------------------------
module pcxd_line_ram #(
   parameter int ADDR_W = 10,
   parameter int DATA_W = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### rtl/pcx_rle_planar_rgb565_decoder.sv
// ----------------------------------------------------------------------------
// pcx_rle_planar_rgb565_decoder
// Decodes the RLE body of a 24-bit three-plane PCX image into RGB565 pixels.
// ----------------------------------------------------------------------------
// A literal byte and a run marker byte are each taken in one handshake. A value
// byte with a run count of n holds the input while its n column steps are
// issued (fewer when the run meets the end of its plane), since the line store
// walks one column per cycle, unless the step stage stalls, through its single
// read and single write port: red and green planes write their top bits into
// the store, the blue plane reads them back and emits a pixel for each column
// below the width. Pixels leave through an output register, so a new byte can
// be taken while a pixel waits. The line store is not cleared after reset;
// each entry is written by the red plane before it is read.
module pcx_rle_planar_rgb565_decoder (
   input  logic                            clock,
   input  logic                            reset,
   pcxd_req_if.sink                        req_ch,
   pcxd_rsp_if.source                      rsp_ch,
   input  logic                            csr_write_en,
   input  logic [pcxd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pcxd_pkg::CSR_DATA_W-1:0] csr_write_data
);

   import pcxd_pkg::*;

   // configuration
   logic [10:0] width_ff;
   logic [10:0] pitch_ff;
   logic [15:0] height_ff;

   // decode state
   plane_type        plane_ff;
   logic [COL_W-1:0] col_ff;
   logic [15:0]      line_ff;
   logic             finished_ff;
   logic             awaiting_ff;
   logic [5:0]       pending_ff;
   logic             run_active_ff;
   logic [5:0]       run_rem_ff;
   logic [7:0]       run_value_ff;

   step_type s1_ff;
   step_type s1_in;

   logic        rsp_valid_ff;
   logic [15:0] rsp_pixel_ff;
   logic [9:0]  rsp_column_ff;
   logic        rsp_eol_ff;
   logic        rsp_eoi_ff;
   logic        rsp_last_ff;

   logic [CNT_W-1:0] pitch_ext;
   logic [CNT_W-1:0] pitch_eff;
   logic [CNT_W-1:0] width_ext;
   logic [CNT_W-1:0] width_eff;
   logic [CNT_W-1:0] col_ext;
   logic [CNT_W-1:0] col_next;
   logic [CNT_W-1:0] s1_col_ext;
   logic [16:0]      line_next;
   logic [15:0]      line_wrap;
   logic             done;
   logic             rsp_free;
   logic             s1_done;
   logic             issue_ok;
   logic             req_accept;
   logic             is_marker;
   logic             lit_put;
   logic             run_put;
   logic             put;
   logic [7:0]       put_value;
   logic             plane_end;
   logic             final_put;
   logic             step_emit;
   logic             step_eol;

   logic             wr_en;
   logic [RG_W-1:0]  wr_data;
   logic [RG_W-1:0]  rd_data;
   logic [RG_W-1:0]  rg;

   // effective geometry
   always_comb begin
      pitch_ext = CNT_W'(pitch_ff);
      width_ext = CNT_W'(width_ff);
      if (pitch_ext == '0) begin
         pitch_eff = CNT_W'(1);
      end else if (pitch_ext > CNT_W'(MAX_PITCH)) begin
         pitch_eff = CNT_W'(MAX_PITCH);
      end else begin
         pitch_eff = pitch_ext;
      end
      width_eff = (width_ext < pitch_eff) ? width_ext : pitch_eff;
   end

   assign done = finished_ff || (line_ff >= height_ff);

   // handshake and step issue
   assign rsp_free   = !rsp_valid_ff || rsp_ch.ready;
   assign s1_done    = !s1_ff.emit || rsp_free;
   assign issue_ok   = !s1_ff.valid || s1_done;
   assign req_ch.ready = !run_active_ff && issue_ok;
   assign req_accept = req_ch.valid && req_ch.ready;
   assign is_marker  = (req_ch.data_byte & RUN_MARK) == RUN_MARK;
   assign lit_put    = req_accept && !done && !awaiting_ff && !is_marker;
   assign run_put    = run_active_ff && issue_ok;
   assign put        = lit_put || run_put;
   assign put_value  = run_active_ff ? run_value_ff : req_ch.data_byte;

   assign col_ext   = CNT_W'(col_ff);
   assign col_next  = col_ext + CNT_W'(1);
   assign plane_end = col_next >= pitch_eff;
   assign final_put = !run_active_ff || (run_rem_ff == 6'd1) || plane_end;
   assign step_emit = (plane_ff == PLANE_BLUE) && (col_ext < width_eff);
   assign step_eol  = col_next == width_eff;
   assign line_next = {1'b0, line_ff} + 17'd1;
   assign line_wrap = line_next[15:0];

   // write-back of red and green bits
   assign rg = s1_ff.fwd ? s1_ff.fwd_data : rd_data;
   assign wr_en = s1_ff.valid && s1_done && (s1_ff.plane != PLANE_BLUE);

   always_comb begin
      if (s1_ff.plane == PLANE_RED) begin
         wr_data = {s1_ff.value[7:3], 6'd0};
      end else begin
         wr_data = {rg[10:6], s1_ff.value[7:2]};
      end
   end

   always_comb begin
      s1_in          = s1_ff;
      if (put) begin
         s1_in.valid    = 1'b1;
         s1_in.plane    = plane_ff;
         s1_in.col      = col_ff;
         s1_in.value    = put_value;
         s1_in.emit     = step_emit;
         s1_in.eol      = step_eol;
         s1_in.eoi      = step_eol && (line_next >= {1'b0, height_ff});
         s1_in.last     = final_put || (col_next >= width_eff);
         // bypass a write to the same column landing in this cycle
         s1_in.fwd      = wr_en && (s1_ff.col == col_ff);
         s1_in.fwd_data = wr_data;
      end else if (s1_done) begin
         s1_in.valid    = 1'b0;
      end
   end

   pcxd_line_ram #(
      .ADDR_W (COL_W),
      .DATA_W (RG_W)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_ff.col),
      .wr_data (wr_data),
      .rd_en   (put),
      .rd_addr (col_ff),
      .rd_data (rd_data)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd1;
         pitch_ff  <= 11'd1;
         height_ff <= 16'd1;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_write_data[10:0];
            CSR_LINE_PITCH:   pitch_ff  <= csr_write_data[10:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // byte parsing and column walk
   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff      <= PLANE_RED;
         col_ff        <= '0;
         line_ff       <= '0;
         finished_ff   <= 1'b0;
         awaiting_ff   <= 1'b0;
         pending_ff    <= '0;
         run_active_ff <= 1'b0;
         run_rem_ff    <= '0;
         run_value_ff  <= '0;
      end else begin
         if (req_accept && !done) begin
            if (awaiting_ff) begin
               awaiting_ff <= 1'b0;
               pending_ff  <= '0;
               if (pending_ff != 6'd0) begin
                  run_active_ff <= 1'b1;
                  run_rem_ff    <= pending_ff;
                  run_value_ff  <= req_ch.data_byte;
               end
            end else if (is_marker) begin
               awaiting_ff <= 1'b1;
               pending_ff  <= req_ch.data_byte[5:0];
            end
         end
         if (run_put) begin
            run_rem_ff <= run_rem_ff - 6'd1;
            if (final_put) begin
               run_active_ff <= 1'b0;
            end
         end
         if (put) begin
            if (plane_end) begin
               col_ff <= '0;
               if (plane_ff == PLANE_BLUE) begin
                  plane_ff <= PLANE_RED;
                  line_ff  <= line_wrap;
                  if (line_wrap >= height_ff) begin
                     finished_ff <= 1'b1;
                  end
               end else begin
                  plane_ff <= plane_ff + 2'd1;
               end
            end else begin
               col_ff <= col_next[COL_W-1:0];
            end
         end
      end
   end

   // step stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else begin
         s1_ff <= s1_in;
      end
   end

   // output register
   assign s1_col_ext = CNT_W'(s1_ff.col);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_ff.valid && s1_ff.emit && rsp_free) begin
         rsp_valid_ff  <= 1'b1;
         rsp_pixel_ff  <= {rg[10:6], rg[5:0], s1_ff.value[7:3]};
         rsp_column_ff <= s1_col_ext[9:0];
         rsp_eol_ff    <= s1_ff.eol;
         rsp_eoi_ff    <= s1_ff.eoi;
         rsp_last_ff   <= s1_ff.last;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.pixel_rgb565 = rsp_pixel_ff;
   assign rsp_ch.column       = rsp_column_ff;
   assign rsp_ch.end_of_line  = rsp_eol_ff;
   assign rsp_ch.end_of_image = rsp_eoi_ff;
   assign rsp_ch.last         = rsp_last_ff;

   // checks
   a_run_blocks_input: assert property (@(posedge clock) disable iff (reset)
      run_active_ff |-> !req_ch.ready)
      else $error("input taken while a run is being expanded");

   a_emit_only_blue: assert property (@(posedge clock) disable iff (reset)
      (s1_ff.valid && s1_ff.emit) |-> (s1_ff.plane == PLANE_BLUE))
      else $error("pixel emitted from a red or green step");

   a_stall_holds_step: assert property (@(posedge clock) disable iff (reset)
      (s1_ff.valid && !s1_done) |=> (s1_ff.valid && $stable(s1_ff.col)))
      else $error("stalled pixel step lost");

   a_eoi_has_eol: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_eoi_ff) |-> (rsp_eol_ff && rsp_last_ff))
      else $error("end of image without end of line and last");

endmodule

### verif/pcx_rle_planar_rgb565_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_planar_rgb565_decoder_tb
// Streams encoded PCX scan lines into the decoder and compares every pixel
// word against a line-accurate software decoder kept in step with each byte
// taken. Geometry changes between lines, and both channels stall at random.
// ----------------------------------------------------------------------------
module pcx_rle_planar_rgb565_decoder_tb;

   import pcxd_pkg::*;

   localparam int RANDOM_BYTES = 250;
   localparam int DRAIN_CYCLES = 100;
   localparam int STALL_LIMIT  = 2000;

   typedef struct packed {
      logic [15:0] pixel;
      logic [9:0]  column;
      logic        eol;
      logic        eoi;
      logic        last;
   } pixel_word_type;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  csr_write_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index      = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;
   logic                  req_valid      = 1'b0;
   logic [7:0]            req_byte       = 8'h00;
   logic                  rsp_ready      = 1'b0;

   pcxd_req_if req_bus ();
   pcxd_rsp_if rsp_bus ();

   assign req_bus.valid     = req_valid;
   assign req_bus.data_byte = req_byte;
   assign rsp_bus.ready     = rsp_ready;

   pcx_rle_planar_rgb565_decoder u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_bus),
      .rsp_ch         (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always #10 clock = ~clock;

   // decoder shadow: geometry, line store and stream position
   int          cfg_width  = 1;
   int          cfg_pitch  = 1;
   int          cfg_height = 1;
   logic [10:0] rg_line [MAX_PITCH];
   plane_type   plane      = PLANE_RED;
   int          plane_col  = 0;
   logic [15:0] line_idx   = '0;
   logic        run_pending = 1'b0;
   int          run_count  = 0;
   logic        image_done = 1'b0;

   pixel_word_type byte_pixels [$];
   pixel_word_type pixels_due [$];
   logic [7:0]  byte_queue [$];
   int          bytes_queued = 0;
   int          bytes_taken  = 0;
   int          error_count  = 0;
   int          src_gap      = 0;
   int          sink_gap     = 0;
   int          stall_cycles = 0;
   logic        steady_flow  = 1'b0;

   function automatic int active_pitch();
      int p;
      p = cfg_pitch;
      if (p == 0) p = 1;
      if (p > MAX_PITCH) p = MAX_PITCH;
      return p;
   endfunction

   // place one value at the current column; 1 when the plane ends
   function automatic bit place_value(input logic [7:0] v);
      int          p;
      int          w;
      int          c;
      logic [10:0] rg;
      pixel_word_type pw;
      p = active_pitch();
      w = (cfg_width < p) ? cfg_width : p;
      c = plane_col;
      if (plane == PLANE_RED) begin
         if (c < MAX_PITCH) rg_line[c] = {v[7:3], 6'd0};
      end else if (plane == PLANE_GREEN) begin
         if (c < MAX_PITCH) rg_line[c] = {rg_line[c][10:6], v[7:2]};
      end else if (c < w && c < MAX_PITCH) begin
         rg        = rg_line[c];
         pw.pixel  = {rg[10:6], rg[5:0], v[7:3]};
         pw.column = 10'(c);
         pw.eol    = (c + 1 == w);
         pw.eoi    = pw.eol && (int'(line_idx) + 1 >= cfg_height);
         pw.last   = 1'b0;
         byte_pixels.push_back(pw);
      end
      plane_col = c + 1;
      if (plane_col >= p) begin
         plane_col = 0;
         if (plane == PLANE_BLUE) begin
            plane    = PLANE_RED;
            line_idx = line_idx + 16'd1;
            if (int'(line_idx) >= cfg_height) image_done = 1'b1;
         end else begin
            plane = (plane == PLANE_RED) ? PLANE_GREEN : PLANE_BLUE;
         end
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic decode_byte(input logic [7:0] b);
      int          cnt;
      int          i;
      bit          plane_end;
      pixel_word_type pw;
      byte_pixels.delete();
      if (image_done || int'(line_idx) >= cfg_height) return;
      if (run_pending) begin
         cnt         = run_count;
         run_pending = 1'b0;
         run_count   = 0;
         i           = 0;
         plane_end   = 1'b0;
         while (i < cnt && !plane_end) begin
            plane_end = place_value(b);
            i++;
         end
      end else if ((b & RUN_MARK) == RUN_MARK) begin
         run_pending = 1'b1;
         run_count   = int'(b[5:0]);
      end else begin
         void'(place_value(b));
      end
      if (byte_pixels.size() > 0) begin
         pw      = byte_pixels.pop_back();
         pw.last = 1'b1;
         byte_pixels.push_back(pw);
      end
      foreach (byte_pixels[k]) pixels_due.push_back(byte_pixels[k]);
   endtask

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic queue_byte(input logic [7:0] b);
      byte_queue.push_back(b);
      bytes_queued++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_write_en   <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH:  cfg_width  = value & 'h7FF;
         CSR_LINE_PITCH:   cfg_pitch  = value & 'h7FF;
         CSR_IMAGE_HEIGHT: cfg_height = value & 'hFFFF;
         default: ;
      endcase
   endtask

   // wait for every byte to be taken and every pixel to arrive, then let the
   // block finish any run that produces nothing
   task automatic wait_drained();
      do @(posedge clock);
      while (bytes_taken != bytes_queued || pixels_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // encode one full scan line (three planes) for the current pitch
   task automatic encode_line();
      int p;
      int c;
      int cnt;
      int r;
      p = active_pitch();
      for (int k = 0; k < 3; k++) begin
         c = 0;
         while (c < p) begin
            r = $urandom_range(0, 99);
            if (p > 64) begin
               if (r < 10) begin
                  queue_byte(8'($urandom_range(0, 191)));
                  c++;
               end else begin
                  cnt = $urandom_range(40, 63);
                  queue_byte(RUN_MARK | 8'(cnt));
                  queue_byte(8'($urandom_range(0, 255)));
                  c += (cnt < p - c) ? cnt : p - c;
               end
            end else if (r < 45) begin
               queue_byte(8'($urandom_range(0, 191)));
               c++;
            end else if (r < 85) begin
               // mostly short runs; long ones get cut at the plane end
               if ($urandom_range(0, 2) == 0) cnt = $urandom_range(1, 63);
               else cnt = $urandom_range(1, 4);
               queue_byte(RUN_MARK | 8'(cnt));
               queue_byte(8'($urandom_range(0, 255)));
               c += (cnt < p - c) ? cnt : p - c;
            end else if (r < 92) begin
               queue_byte(RUN_MARK);
               queue_byte(8'($urandom_range(0, 255)));
            end else begin
               queue_byte(RUN_MARK | 8'd1);
               queue_byte(8'($urandom_range(192, 255)));
               c++;
            end
         end
      end
   endtask

   // byte driver
   always @(posedge clock) begin
      logic       nv;
      logic [7:0] nd;
      nv = req_valid;
      nd = req_byte;
      if (reset) begin
         nv = 1'b0;
      end else begin
         if (req_valid && req_bus.ready) begin
            decode_byte(req_byte);
            bytes_taken++;
            nv = 1'b0;
         end
         if (!nv) begin
            if (src_gap > 0) begin
               src_gap--;
            end else if (byte_queue.size() > 0) begin
               if (!steady_flow && $urandom_range(0, 9) == 0) begin
                  src_gap = $urandom_range(1, 13) - 1;
               end else begin
                  nd = byte_queue.pop_front();
                  nv = 1'b1;
               end
            end
         end
      end
      req_valid <= nv;
      req_byte  <= nd;
   end

   // pixel monitor
   always @(posedge clock) begin
      logic        nr;
      pixel_word_type got;
      pixel_word_type want;
      nr = rsp_ready;
      if (reset) begin
         nr = 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_ready) begin
            got = '{rsp_bus.pixel_rgb565, rsp_bus.column, rsp_bus.end_of_line,
                    rsp_bus.end_of_image, rsp_bus.last};
            if (pixels_due.size() == 0) begin
               report_mismatch($sformatf("unexpected pixel word %h col %0d",
                                         got.pixel, got.column));
            end else begin
               want = pixels_due.pop_front();
               if (got.pixel !== want.pixel)
                  report_mismatch($sformatf("pixel %h, want %h (col %0d)",
                                            got.pixel, want.pixel, want.column));
               if (got.column !== want.column)
                  report_mismatch($sformatf("column %0d, want %0d",
                                            got.column, want.column));
               if (got.eol !== want.eol)
                  report_mismatch($sformatf("end_of_line %b, want %b (col %0d)",
                                            got.eol, want.eol, want.column));
               if (got.eoi !== want.eoi)
                  report_mismatch($sformatf("end_of_image %b, want %b (col %0d)",
                                            got.eoi, want.eoi, want.column));
               if (got.last !== want.last)
                  report_mismatch($sformatf("last %b, want %b (col %0d)",
                                            got.last, want.last, want.column));
            end
         end
         if (sink_gap > 0) begin
            sink_gap--;
            nr = 1'b0;
         end else if (!steady_flow && $urandom_range(0, 11) == 0) begin
            sink_gap = $urandom_range(1, 13) - 1;
            nr       = 1'b0;
         end else begin
            nr = 1'b1;
         end
      end
      rsp_ready <= nr;
   end

   // watchdog: too long without any word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_bus.ready) || (rsp_bus.valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int phase;
      int w;
      int p;
      int lines;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      write_reg(CSR_IMAGE_HEIGHT, 65535);
      write_reg(CSR_IMAGE_WIDTH, 3);
      write_reg(CSR_LINE_PITCH, 4);
      // red: full-length run cut at the plane end
      queue_byte(8'hFF); queue_byte(8'hFF);
      // green: zero-count run, then literal extremes
      queue_byte(8'hC0); queue_byte(8'h55);
      queue_byte(8'h00); queue_byte(8'h3F); queue_byte(8'hBF); queue_byte(8'h80);
      // blue: run, literal, single run into the padding column
      queue_byte(8'hC2); queue_byte(8'hFF); queue_byte(8'h12);
      queue_byte(8'hC1); queue_byte(8'h7F);
      wait_drained();

      // zero width and zero pitch: the line is consumed silently
      write_reg(CSR_IMAGE_WIDTH, 0);
      write_reg(CSR_LINE_PITCH, 0);
      queue_byte(8'h01); queue_byte(8'h02); queue_byte(8'h03);
      wait_drained();

      // width far above the pitch
      write_reg(CSR_IMAGE_WIDTH, 2047);
      write_reg(CSR_LINE_PITCH, 1);
      queue_byte(8'h40); queue_byte(8'h80); queue_byte(8'hB8);
      wait_drained();

      phase = 0;
      while (bytes_queued < 19 + RANDOM_BYTES) begin
         case (phase)
            0: begin w = 2047; p = 1024; end
            1: begin w = 1;    p = 1;    end
            2: begin w = 12;   p = 12;   end
            default: begin
               p = $urandom_range(0, 12);
               if ($urandom_range(0, 2) == 0) w = $urandom_range(0, 15);
               else w = $urandom_range(1, (p == 0) ? 1 : p);
            end
         endcase
         write_reg(CSR_IMAGE_WIDTH, w);
         write_reg(CSR_LINE_PITCH, p);
         lines = (p > 64) ? 1 : $urandom_range(1, 4);
         repeat (lines) encode_line();
         wait_drained();
         phase++;
      end

      // closing line ends the image; trailing bytes must be ignored
      steady_flow = 1'b1;
      write_reg(CSR_IMAGE_HEIGHT, int'(line_idx) + 1);
      write_reg(CSR_IMAGE_WIDTH, 8);
      write_reg(CSR_LINE_PITCH, 9);
      encode_line();
      queue_byte(8'hC5); queue_byte(8'h33); queue_byte(8'h10);
      wait_drained();
      write_reg(CSR_IMAGE_HEIGHT, 0);
      queue_byte(8'h21); queue_byte(8'hC3); queue_byte(8'h9A);
      wait_drained();

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/pcxd_pkg.sv
rtl/pcxd_req_if.sv
rtl/pcxd_rsp_if.sv
rtl/pcxd_line_ram.sv
rtl/pcx_rle_planar_rgb565_decoder.sv
verif/pcx_rle_planar_rgb565_decoder_tb.sv
